@@ rtl/textok_pkg.sv @@
// ----------------------------------------------------------------------------
// textok_pkg
// shared types, category codes and sizes for the tex tokenizer
// ----------------------------------------------------------------------------
package textok_pkg;

	localparam int QueueDepth = 4;

	localparam int ByteW = 8;
	localparam int CatW  = 5;

	localparam logic FUNC_TEXT = 1'b0;
	localparam logic FUNC_END  = 1'b1;

	localparam logic [CatW-1:0] CC_ESC     = 5'd0;
	localparam logic [CatW-1:0] CC_BGROUP  = 5'd1;
	localparam logic [CatW-1:0] CC_EGROUP  = 5'd2;
	localparam logic [CatW-1:0] CC_MATH    = 5'd3;
	localparam logic [CatW-1:0] CC_ALIGN   = 5'd4;
	localparam logic [CatW-1:0] CC_EOL     = 5'd5;
	localparam logic [CatW-1:0] CC_PARAM   = 5'd6;
	localparam logic [CatW-1:0] CC_SUPER   = 5'd7;
	localparam logic [CatW-1:0] CC_SUB     = 5'd8;
	localparam logic [CatW-1:0] CC_IGNORE  = 5'd9;
	localparam logic [CatW-1:0] CC_BLANK   = 5'd10;
	localparam logic [CatW-1:0] CC_ALPHA   = 5'd11;
	localparam logic [CatW-1:0] CC_MISC    = 5'd12;
	localparam logic [CatW-1:0] CC_TILDE   = 5'd13;
	localparam logic [CatW-1:0] CC_REMARK  = 5'd14;
	localparam logic [CatW-1:0] CC_BAD     = 5'd15;
	localparam logic [CatW-1:0] CC_CSEQ    = 5'd16;

	typedef enum logic [1:0] {
		MODE_INITIAL = 2'd0,
		MODE_CS      = 2'd1,
		MODE_COMMENT = 2'd2
	} lex_mode_t;

	typedef struct packed {
		logic [ByteW-1:0] out_byte;
		logic             byte_valid;
		logic [CatW-1:0]  token_cat;
		logic             token_last;
	} res_t;

	typedef struct packed {
		res_t first;
		res_t second;
		logic two;
	} cmd_t;

	typedef struct packed {
		logic push;
		cmd_t data;
	} push_t;

	typedef struct packed {
		logic empty;
		cmd_t data;
	} head_t;

endpackage

@@ rtl/textok_in_if.sv @@
// ----------------------------------------------------------------------------
// textok_in_if
// text byte channel: valid/ready with function code and byte
// ----------------------------------------------------------------------------
interface textok_in_if;

	logic                           valid;
	logic                           ready;
	logic                           func;
	logic [textok_pkg::ByteW-1:0]   data_byte;

	modport source (output valid, output func, output data_byte, input ready);
	modport sink (input valid, input func, input data_byte, output ready);

endinterface

@@ rtl/textok_out_if.sv @@
// ----------------------------------------------------------------------------
// textok_out_if
// token channel: valid/ready with one tagged byte or end marker per item
// ----------------------------------------------------------------------------
interface textok_out_if;

	logic                          valid;
	logic                          ready;
	logic [textok_pkg::ByteW-1:0]  out_byte;
	logic                          byte_valid;
	logic [textok_pkg::CatW-1:0]   token_cat;
	logic                          token_last;
	logic                          run_last;

	modport source (output valid, output out_byte, output byte_valid,
		output token_cat, output token_last, output run_last, input ready);
	modport sink (input valid, input out_byte, input byte_valid,
		input token_cat, input token_last, input run_last, output ready);

endinterface

@@ rtl/textok_front.sv @@
// ----------------------------------------------------------------------------
// textok_front
// classifies each text byte and tracks the lexer mode, producing one
// command of one or two results per item, none for end of text between tokens
// ----------------------------------------------------------------------------
module textok_front (
	input  logic                 clk,
	input  logic                 arst_n,
	textok_in_if.sink            text,
	input  logic                 full,
	output textok_pkg::push_t    push
);

	typedef struct packed {
		textok_pkg::res_t      res;
		textok_pkg::lex_mode_t mode;
	} start_t;

	textok_pkg::lex_mode_t    mode_q, mode_d;
	logic                     letters_q, letters_d;
	logic [textok_pkg::CatW-1:0] cat;
	logic                     accept;
	start_t                   st;
	textok_pkg::cmd_t         cmd;
	logic                     has_res;

	function automatic logic [textok_pkg::CatW-1:0] classify(
		input logic [textok_pkg::ByteW-1:0] b);
		logic [textok_pkg::CatW-1:0] c;
		case (b) inside
			[8'h41:8'h5A], [8'h61:8'h7A]: c = textok_pkg::CC_ALPHA;
			8'h5C:                        c = textok_pkg::CC_ESC;
			8'h7B:                        c = textok_pkg::CC_BGROUP;
			8'h7D:                        c = textok_pkg::CC_EGROUP;
			8'h24:                        c = textok_pkg::CC_MATH;
			8'h26:                        c = textok_pkg::CC_ALIGN;
			8'h23:                        c = textok_pkg::CC_PARAM;
			8'h5E:                        c = textok_pkg::CC_SUPER;
			8'h5F:                        c = textok_pkg::CC_SUB;
			8'h7E:                        c = textok_pkg::CC_TILDE;
			8'h20, 8'h09:                 c = textok_pkg::CC_BLANK;
			8'h0A, 8'h0D:                 c = textok_pkg::CC_EOL;
			8'h25:                        c = textok_pkg::CC_REMARK;
			8'h7F:                        c = textok_pkg::CC_BAD;
			8'h00:                        c = textok_pkg::CC_IGNORE;
			default:                      c = textok_pkg::CC_MISC;
		endcase
		return c;
	endfunction

	// a byte seen between tokens
	function automatic start_t start_token(input logic [textok_pkg::ByteW-1:0] b,
		input logic [textok_pkg::CatW-1:0] c);
		start_t s;
		s.res.out_byte   = b;
		s.res.byte_valid = 1'b1;
		if (c == textok_pkg::CC_REMARK) begin
			s.res.token_cat  = textok_pkg::CC_REMARK;
			s.res.token_last = 1'b0;
			s.mode           = textok_pkg::MODE_COMMENT;
		end else if (c == textok_pkg::CC_ESC) begin
			s.res.token_cat  = textok_pkg::CC_CSEQ;
			s.res.token_last = 1'b0;
			s.mode           = textok_pkg::MODE_CS;
		end else begin
			s.res.token_cat  = c;
			s.res.token_last = 1'b1;
			s.mode           = textok_pkg::MODE_INITIAL;
		end
		return s;
	endfunction

	assign text.ready = !full;
	assign accept     = text.valid && !full;
	assign cat        = classify(text.data_byte);
	assign st         = start_token(text.data_byte, cat);

	always_comb begin
		mode_d     = mode_q;
		letters_d  = letters_q;
		has_res    = 1'b1;
		cmd.two    = 1'b0;
		cmd.first  = st.res;
		cmd.second = st.res;
		if (text.func == textok_pkg::FUNC_END) begin
			cmd.first.out_byte   = '0;
			cmd.first.byte_valid = 1'b0;
			cmd.first.token_last = 1'b1;
			mode_d               = textok_pkg::MODE_INITIAL;
			letters_d            = 1'b0;
			case (mode_q)
				textok_pkg::MODE_CS:      cmd.first.token_cat = textok_pkg::CC_CSEQ;
				textok_pkg::MODE_COMMENT: cmd.first.token_cat = textok_pkg::CC_REMARK;
				default: begin
					cmd.first.token_cat = textok_pkg::CC_CSEQ;
					has_res             = 1'b0;
				end
			endcase
		end else begin
			case (mode_q)
				textok_pkg::MODE_COMMENT: begin
					cmd.first.token_cat  = textok_pkg::CC_REMARK;
					cmd.first.token_last = (cat == textok_pkg::CC_EOL);
					if (cat == textok_pkg::CC_EOL) begin
						mode_d = textok_pkg::MODE_INITIAL;
					end
				end
				textok_pkg::MODE_CS: begin
					cmd.first.token_cat = textok_pkg::CC_CSEQ;
					if (cat == textok_pkg::CC_ALPHA) begin
						cmd.first.token_last = 1'b0;
						letters_d            = 1'b1;
					end else if (!letters_q) begin
						cmd.first.token_last = 1'b1;
						mode_d               = textok_pkg::MODE_INITIAL;
					end else begin
						// letter run ended: end marker, then the byte afresh
						cmd.first.out_byte   = '0;
						cmd.first.byte_valid = 1'b0;
						cmd.first.token_last = 1'b1;
						cmd.two              = 1'b1;
						letters_d            = 1'b0;
						mode_d               = st.mode;
					end
				end
				default: begin
					mode_d = st.mode;
					if (st.mode == textok_pkg::MODE_CS) begin
						letters_d = 1'b0;
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= textok_pkg::MODE_INITIAL;
			letters_q <= 1'b0;
		end else if (accept) begin
			mode_q    <= mode_d;
			letters_q <= letters_d;
		end
	end

	assign push.push = accept && has_res;
	assign push.data = cmd;

endmodule

@@ rtl/textok_fifo.sv @@
// ----------------------------------------------------------------------------
// textok_fifo
// short command queue between the classifier and the result sequencer
// ----------------------------------------------------------------------------
module textok_fifo #(
	parameter int DEPTH = textok_pkg::QueueDepth
) (
	input  logic              clk,
	input  logic              arst_n,
	input  textok_pkg::push_t push,
	output logic              full,
	input  logic              pop,
	output textok_pkg::head_t head
);

	localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CntW = $clog2(DEPTH + 1);

	textok_pkg::cmd_t mem_q [DEPTH];
	logic [PtrW-1:0]  wr_ptr_q;
	logic [PtrW-1:0]  rd_ptr_q;
	logic [CntW-1:0]  count_q;
	logic             do_push;
	logic             do_pop;

	assign full       = (count_q == CntW'(DEPTH));
	assign head.empty = (count_q == '0);
	assign head.data  = mem_q[rd_ptr_q];
	assign do_push    = push.push && !full;
	assign do_pop     = pop && !head.empty;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

@@ rtl/textok_back.sv @@
// ----------------------------------------------------------------------------
// textok_back
// expands queued commands into result items through one output register
// ----------------------------------------------------------------------------
module textok_back (
	input  logic              clk,
	input  logic              arst_n,
	input  textok_pkg::head_t head,
	output logic              pop,
	textok_out_if.source      token
);

	logic             out_valid_q;
	textok_pkg::res_t out_res_q;
	logic             run_last_q;
	logic             sec_valid_q;
	textok_pkg::res_t sec_q;
	logic             load;

	assign load = !out_valid_q || token.ready;
	assign pop  = load && !sec_valid_q && !head.empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			sec_valid_q <= 1'b0;
		end else if (load) begin
			if (sec_valid_q) begin
				out_valid_q <= 1'b1;
				sec_valid_q <= 1'b0;
			end else begin
				out_valid_q <= !head.empty;
				sec_valid_q <= !head.empty && head.data.two;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			if (sec_valid_q) begin
				out_res_q  <= sec_q;
				run_last_q <= 1'b1;
			end else begin
				out_res_q  <= head.data.first;
				run_last_q <= !head.data.two;
				sec_q      <= head.data.second;
			end
		end
	end

	assign token.valid      = out_valid_q;
	assign token.out_byte   = out_res_q.out_byte;
	assign token.byte_valid = out_res_q.byte_valid;
	assign token.token_cat  = out_res_q.token_cat;
	assign token.token_last = out_res_q.token_last;
	assign token.run_last   = run_last_q;

endmodule

@@ rtl/tex_tokenizer.sv @@
// ----------------------------------------------------------------------------
// tex_tokenizer
// tex default catcode tokenizer: tags every text byte with its token's
// category and marks token ends
// ----------------------------------------------------------------------------
// One text item is taken per clock while the command queue has room. An item
// yields zero, one or two result items; the output register sends one result
// per clock while the receiver is ready, and an item that ends a lettered
// control sequence with a non-letter yields an end marker and then the byte.
// An accepted item enters the command queue at its accepting edge and then
// the output register, from which its results are sent. End of text between
// tokens yields no result; otherwise it closes the open control sequence or
// comment with a byteless end marker.
module tex_tokenizer #(
	parameter int QUEUE_DEPTH = textok_pkg::QueueDepth
) (
	input  logic          clk,
	input  logic          arst_n,
	textok_in_if.sink     text,
	textok_out_if.source  token
);

	textok_pkg::push_t push;
	textok_pkg::head_t head;
	logic              full;
	logic              pop;

	textok_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.text   (text),
		.full   (full),
		.push   (push)
	);

	textok_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (full),
		.pop    (pop),
		.head   (head)
	);

	textok_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head),
		.pop    (pop),
		.token  (token)
	);

endmodule

@@ tb/sv/tex_tokenizer_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tex_tokenizer_checker
// watches the text and token channels, predicts the token items that each
// accepted text item causes and compares every token item in arrival order
// ----------------------------------------------------------------------------
module tex_tokenizer_checker (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	input  logic                         in_ready,
	input  logic                         in_func,
	input  logic [textok_pkg::ByteW-1:0] in_byte,
	input  logic                         out_valid,
	input  logic                         out_ready,
	input  logic [textok_pkg::ByteW-1:0] out_byte,
	input  logic                         out_byte_valid,
	input  logic [textok_pkg::CatW-1:0]  out_cat,
	input  logic                         out_token_last,
	input  logic                         out_run_last,
	output int                           fail_count,
	output int                           pending
);

	typedef struct packed {
		logic [textok_pkg::ByteW-1:0] out_byte;
		logic                         byte_valid;
		logic [textok_pkg::CatW-1:0]  token_cat;
		logic                         token_last;
		logic                         run_last;
	} token_item_t;

	token_item_t           expected_tokens[$];
	textok_pkg::lex_mode_t mode       = textok_pkg::MODE_INITIAL;
	logic                  cs_letters = 1'b0;
	int                    errors     = 0;
	int                    burst      = 0;

	function automatic logic [textok_pkg::CatW-1:0] catcode(
		input logic [textok_pkg::ByteW-1:0] b);
		if (b inside {["A":"Z"], ["a":"z"]})
			return textok_pkg::CC_ALPHA;
		case (b)
		"\\":        return textok_pkg::CC_ESC;
		"{":         return textok_pkg::CC_BGROUP;
		"}":         return textok_pkg::CC_EGROUP;
		"$":         return textok_pkg::CC_MATH;
		"&":         return textok_pkg::CC_ALIGN;
		"#":         return textok_pkg::CC_PARAM;
		"^":         return textok_pkg::CC_SUPER;
		"_":         return textok_pkg::CC_SUB;
		"~":         return textok_pkg::CC_TILDE;
		" ", "\t":   return textok_pkg::CC_BLANK;
		"\n", "\r":  return textok_pkg::CC_EOL;
		"%":         return textok_pkg::CC_REMARK;
		8'd127:      return textok_pkg::CC_BAD;
		8'd0:        return textok_pkg::CC_IGNORE;
		default:     return textok_pkg::CC_MISC;
		endcase
	endfunction

	task automatic add_token(input logic [textok_pkg::ByteW-1:0] b, input logic v,
			input logic [textok_pkg::CatW-1:0] cat, input logic last);
		token_item_t t;
		t.out_byte   = b;
		t.byte_valid = v;
		t.token_cat  = cat;
		t.token_last = last;
		t.run_last   = 1'b0;
		expected_tokens.push_back(t);
		burst++;
	endtask

	// byte seen between tokens
	task automatic open_token(input logic [textok_pkg::ByteW-1:0] b,
			input logic [textok_pkg::CatW-1:0] cat);
		if (cat == textok_pkg::CC_REMARK) begin
			add_token(b, 1'b1, textok_pkg::CC_REMARK, 1'b0);
			mode = textok_pkg::MODE_COMMENT;
		end else if (cat == textok_pkg::CC_ESC) begin
			add_token(b, 1'b1, textok_pkg::CC_CSEQ, 1'b0);
			mode       = textok_pkg::MODE_CS;
			cs_letters = 1'b0;
		end else begin
			add_token(b, 1'b1, cat, 1'b1);
			mode = textok_pkg::MODE_INITIAL;
		end
	endtask

	task automatic predict_tokens(input logic f, input logic [textok_pkg::ByteW-1:0] b);
		logic [textok_pkg::CatW-1:0] cat;
		token_item_t                 t;
		cat   = catcode(b);
		burst = 0;
		if (f == textok_pkg::FUNC_END) begin
			if (mode == textok_pkg::MODE_CS)
				add_token(8'd0, 1'b0, textok_pkg::CC_CSEQ, 1'b1);
			else if (mode == textok_pkg::MODE_COMMENT)
				add_token(8'd0, 1'b0, textok_pkg::CC_REMARK, 1'b1);
			mode       = textok_pkg::MODE_INITIAL;
			cs_letters = 1'b0;
		end else if (mode == textok_pkg::MODE_COMMENT) begin
			add_token(b, 1'b1, textok_pkg::CC_REMARK, cat == textok_pkg::CC_EOL);
			if (cat == textok_pkg::CC_EOL)
				mode = textok_pkg::MODE_INITIAL;
		end else if (mode == textok_pkg::MODE_CS) begin
			if (cat == textok_pkg::CC_ALPHA) begin
				add_token(b, 1'b1, textok_pkg::CC_CSEQ, 1'b0);
				cs_letters = 1'b1;
			end else if (!cs_letters) begin
				add_token(b, 1'b1, textok_pkg::CC_CSEQ, 1'b1);
				mode = textok_pkg::MODE_INITIAL;
			end else begin
				// letter run ends: byteless marker, then the byte afresh
				add_token(8'd0, 1'b0, textok_pkg::CC_CSEQ, 1'b1);
				cs_letters = 1'b0;
				open_token(b, cat);
			end
		end else begin
			open_token(b, cat);
		end
		if (burst > 0) begin
			t = expected_tokens.pop_back();
			t.run_last = 1'b1;
			expected_tokens.push_back(t);
		end
	endtask

	always @(posedge clk) begin : watch
		token_item_t want;
		token_item_t got;
		if (!arst_n) begin
			mode       = textok_pkg::MODE_INITIAL;
			cs_letters = 1'b0;
			expected_tokens.delete();
		end else begin
			if (out_valid && out_ready) begin
				got.out_byte   = out_byte;
				got.byte_valid = out_byte_valid;
				got.token_cat  = out_cat;
				got.token_last = out_token_last;
				got.run_last   = out_run_last;
				if (expected_tokens.size() == 0) begin
					if (errors < 10)
						$display("%0t: unexpected token item: byte %h valid %b %s",
							$time, got.out_byte, got.byte_valid,
							$sformatf("cat %0d last %b run %b", got.token_cat,
								got.token_last, got.run_last));
					errors++;
				end else begin
					want = expected_tokens.pop_front();
					if (got !== want) begin
						if (errors < 10) begin
							$write("%0t: token mismatch: expected byte %h valid %b",
								$time, want.out_byte, want.byte_valid);
							$write(" cat %0d last %b run %b,", want.token_cat,
								want.token_last, want.run_last);
							$write(" got byte %h valid %b", got.out_byte,
								got.byte_valid);
							$display(" cat %0d last %b run %b", got.token_cat,
								got.token_last, got.run_last);
						end
						errors++;
					end
				end
			end
			if (in_valid && in_ready)
				predict_tokens(in_func, in_byte);
		end
		fail_count <= errors;
		pending    <= expected_tokens.size();
	end

endmodule

@@ tb/sv/tex_tokenizer_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tex_tokenizer_test
// drives directed and random text through the tokenizer under several idle
// and stall patterns; a checker beside the block predicts and compares
// ----------------------------------------------------------------------------
module tex_tokenizer_test;

	localparam int PhaseItems = 425;
	localparam int StallLimit = 2000;

	logic clk;
	logic arst_n     = 1'b0;
	int   send_idle  = 0;
	int   recv_stall = 0;
	int   sent       = 0;
	int   fail_count;
	int   pending;

	textok_in_if  text_ch ();
	textok_out_if token_ch ();

	tex_tokenizer uut (
		.clk    (clk),
		.arst_n (arst_n),
		.text   (text_ch),
		.token  (token_ch)
	);

	tex_tokenizer_checker chk (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (text_ch.valid),
		.in_ready       (text_ch.ready),
		.in_func        (text_ch.func),
		.in_byte        (text_ch.data_byte),
		.out_valid      (token_ch.valid),
		.out_ready      (token_ch.ready),
		.out_byte       (token_ch.out_byte),
		.out_byte_valid (token_ch.byte_valid),
		.out_cat        (token_ch.token_cat),
		.out_token_last (token_ch.token_last),
		.out_run_last   (token_ch.run_last),
		.fail_count     (fail_count),
		.pending        (pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		token_ch.ready <= ($urandom_range(99) >= recv_stall);
	end

	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < StallLimit) begin
			@(posedge clk);
			if ((text_ch.valid && text_ch.ready) || (token_ch.valid && token_ch.ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("Simulation FAILED");
		$finish;
	end

	task automatic send_item(input logic f, input logic [textok_pkg::ByteW-1:0] b);
		while ($urandom_range(99) < send_idle) begin
			text_ch.valid <= 1'b0;
			@(posedge clk);
		end
		text_ch.valid     <= 1'b1;
		text_ch.func      <= f;
		text_ch.data_byte <= b;
		@(posedge clk);
		while (!text_ch.ready)
			@(posedge clk);
		sent++;
	endtask

	function automatic logic [textok_pkg::ByteW-1:0] letter();
		logic [textok_pkg::ByteW-1:0] base;
		base = $urandom_range(1) ? "A" : "a";
		return base + 8'($urandom_range(25));
	endfunction

	function automatic logic [textok_pkg::ByteW-1:0] any_byte();
		case ($urandom_range(3))
		0, 1: return letter();
		2: begin
			case ($urandom_range(15))
			0:       return "\\";
			1:       return "{";
			2:       return "}";
			3:       return "$";
			4:       return "&";
			5:       return "#";
			6:       return "^";
			7:       return "_";
			8:       return "~";
			9:       return " ";
			10:      return "\t";
			11:      return "\n";
			12:      return "\r";
			13:      return "%";
			14:      return 8'd127;
			default: return 8'd0;
			endcase
		end
		default: return 8'($urandom_range(255));
		endcase
	endfunction

	task automatic random_token();
		int kind;
		kind = $urandom_range(99);
		if (kind < 30) begin
			send_item(textok_pkg::FUNC_TEXT, any_byte());
		end else if (kind < 55) begin
			// control word with a random terminator
			send_item(textok_pkg::FUNC_TEXT, "\\");
			repeat ($urandom_range(6, 1))
				send_item(textok_pkg::FUNC_TEXT, letter());
			send_item(textok_pkg::FUNC_TEXT, any_byte());
		end else if (kind < 65) begin
			send_item(textok_pkg::FUNC_TEXT, "\\");
			send_item(textok_pkg::FUNC_TEXT, any_byte());
		end else if (kind < 78) begin
			send_item(textok_pkg::FUNC_TEXT, "%");
			repeat ($urandom_range(6))
				send_item(textok_pkg::FUNC_TEXT, any_byte());
			send_item(textok_pkg::FUNC_TEXT, $urandom_range(1) ? "\n" : "\r");
		end else if (kind < 85) begin
			send_item(textok_pkg::FUNC_END, 8'($urandom_range(255)));
		end else begin
			send_item($urandom_range(7) == 0, 8'($urandom_range(255)));
		end
	endtask

	initial begin : stimulus
		int target;
		text_ch.valid     = 1'b0;
		text_ch.func      = textok_pkg::FUNC_TEXT;
		text_ch.data_byte = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// byte extremes and plain categories
		send_item(textok_pkg::FUNC_TEXT, 8'd0);
		send_item(textok_pkg::FUNC_TEXT, 8'd255);
		send_item(textok_pkg::FUNC_TEXT, 8'd127);
		send_item(textok_pkg::FUNC_TEXT, "{");
		send_item(textok_pkg::FUNC_TEXT, "}");
		send_item(textok_pkg::FUNC_TEXT, "~");
		send_item(textok_pkg::FUNC_TEXT, " ");
		send_item(textok_pkg::FUNC_TEXT, "A");
		// control word ended by a non-letter
		send_item(textok_pkg::FUNC_TEXT, "\\");
		send_item(textok_pkg::FUNC_TEXT, "a");
		send_item(textok_pkg::FUNC_TEXT, "z");
		send_item(textok_pkg::FUNC_TEXT, "1");
		// control symbol
		send_item(textok_pkg::FUNC_TEXT, "\\");
		send_item(textok_pkg::FUNC_TEXT, "%");
		// comment through end of line
		send_item(textok_pkg::FUNC_TEXT, "%");
		send_item(textok_pkg::FUNC_TEXT, "Z");
		send_item(textok_pkg::FUNC_TEXT, "\r");
		// end of text on a lone backslash, in a comment, between tokens
		send_item(textok_pkg::FUNC_TEXT, "\\");
		send_item(textok_pkg::FUNC_END, 8'd255);
		send_item(textok_pkg::FUNC_TEXT, "%");
		send_item(textok_pkg::FUNC_END, 8'd0);
		send_item(textok_pkg::FUNC_END, 8'd170);
		// end of text in a control word
		send_item(textok_pkg::FUNC_TEXT, "\\");
		send_item(textok_pkg::FUNC_TEXT, "x");
		send_item(textok_pkg::FUNC_END, 8'd85);

		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
			0: begin
				send_idle  = 0;
				recv_stall = 0;
			end
			1: begin
				send_idle  = 54;
				recv_stall = 0;
			end
			2: begin
				send_idle  = 0;
				recv_stall = 54;
			end
			default: begin
				send_idle  = 23;
				recv_stall = 23;
			end
			endcase
			target = sent + PhaseItems;
			while (sent < target)
				random_token();
		end
		text_ch.valid <= 1'b0;

		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
